// ===== rtl/salru_pkg.sv =====
// ----------------------------------------------------------------------------
// salru_pkg
// Shared widths, operation codes, outcome codes and register map of the
// set-associative LRU lookup block.
// ----------------------------------------------------------------------------
package salru_pkg;

  localparam int OP_W    = 2;
  localparam int ADDR_W  = 32;
  localparam int OUTC_W  = 2;
  localparam int CNT_W   = 32;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  localparam int SET_BITS_W   = 3;
  localparam int BLOCK_BITS_W = 5;
  localparam int WAYS_W       = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
  localparam logic [OP_W-1:0] OP_IFETCH = 2'd3;

  // lookup outcome codes
  localparam logic [OUTC_W-1:0] OUTC_IGNORED = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_HIT     = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_MISS    = 2'd2;
  localparam logic [OUTC_W-1:0] OUTC_EVICT   = 2'd3;

  // register indexes (byte address 4*i)
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd0;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd0;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 3'd1;

endpackage

// ===== rtl/salru_req_if.sv =====
// ----------------------------------------------------------------------------
// salru_req_if
// Access request channel: operation and byte address.
// ----------------------------------------------------------------------------
interface salru_req_if;
  import salru_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] address;

  modport source (output valid, operation, address, input ready);
  modport sink   (input valid, operation, address, output ready);

endinterface

// ===== rtl/salru_rsp_if.sv =====
// ----------------------------------------------------------------------------
// salru_rsp_if
// Lookup result channel: outcome, second hit flag and running totals.
// ----------------------------------------------------------------------------
interface salru_rsp_if;
  import salru_pkg::*;

  logic              valid;
  logic              ready;
  logic [OUTC_W-1:0] first_outcome;
  logic              second_hit;
  logic [CNT_W-1:0]  hit_total;
  logic [CNT_W-1:0]  miss_total;
  logic [CNT_W-1:0]  evict_total;

  modport source (output valid, first_outcome, second_hit, hit_total, miss_total,
                  evict_total, input ready);
  modport sink   (input valid, first_outcome, second_hit, hit_total, miss_total,
                  evict_total, output ready);

endinterface

// ===== rtl/set_assoc_cache_lru_lookup.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup
// Tag store of a set-associative cache with true LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one access (operation, address) per beat; rsp_o returns one
//   beat per access with the outcome of the first lookup, the second-lookup
//   hit flag of a modify, and saturating hit, miss and eviction totals.
//   The APB port writes set_bits, block_bits and ways_in_use at 0x0, 0x4,
//   0x8; pready is tied high. Write them only while the block is idle.
// Timing:
//   A request reads its set row from the line memory when it is accepted;
//   it is resolved in the resolve stage and, as that stage advances, is
//   written back (not for a fetch) and its result loaded into the output
//   register. One access per cycle while results are taken, modify included;
//   a same-set access right behind is served from a write-back bypass. One
//   row read and one row write-back per cycle set this rate.
// Reset:
//   All lines invalid, totals zero, one set, one way. No clearing pass.
// Stall:
//   While the result is not taken the resolve stage holds, and req_i.ready
//   drops once that stage is also full.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  salru_req_if.sink                     req_i,
  salru_rsp_if.source                   rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [salru_pkg::CFG_AW-1:0]  paddr,
  input  logic [salru_pkg::CFG_DW-1:0]  pwdata,
  output logic [salru_pkg::CFG_DW-1:0]  prdata,
  output logic                          pready
);
  import salru_pkg::*;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AGE_W    = WAY_W;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

  typedef struct packed {
    logic [MAX_WAYS-1:0][ADDR_W-1:0] tag;
    logic [MAX_WAYS-1:0][AGE_W-1:0]  age;
  } row_t;

  // configuration registers
  logic [SET_BITS_W-1:0]   set_bits_q;
  logic [BLOCK_BITS_W-1:0] block_bits_q;
  logic [WAYS_W-1:0]       ways_q;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= SET_BITS_RST;
      block_bits_q <= BLOCK_BITS_RST;
      ways_q       <= WAYS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SET_BITS:   set_bits_q   <= pwdata[SET_BITS_W-1:0];
        REG_BLOCK_BITS: block_bits_q <= pwdata[BLOCK_BITS_W-1:0];
        REG_WAYS:       ways_q       <= pwdata[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SET_BITS:   prdata = CFG_DW'(set_bits_q);
      REG_BLOCK_BITS: prdata = CFG_DW'(block_bits_q);
      REG_WAYS:       prdata = CFG_DW'(ways_q);
      default:        prdata = '0;
    endcase
  end

  // address split
  logic [SET_BITS_W-1:0] sb;
  logic [5:0]            sbb;
  logic [ADDR_W-1:0]     set_mask;
  logic [ADDR_W-1:0]     set_full;
  logic [SET_W-1:0]      in_set;
  logic [ADDR_W-1:0]     in_tag;

  always_comb begin
    sb       = (int'(set_bits_q) > MAX_SET_BITS) ? SET_BITS_W'(MAX_SET_BITS) : set_bits_q;
    sbb      = 6'(sb) + 6'(block_bits_q);
    set_mask = (ADDR_W'(1) << sb) - ADDR_W'(1);
    set_full = (req_i.address >> block_bits_q) & set_mask;
    in_set   = set_full[SET_W-1:0];
    in_tag   = (sbb < 6'd32) ? (req_i.address >> sbb) : '0;
  end

  // pipeline control
  logic s1_vld_q;
  logic out_vld_q;
  logic s1_adv;
  logic in_acc;
  logic wr_en;

  assign s1_adv      = s1_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !s1_vld_q || s1_adv;
  assign in_acc      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // stage 1 payload
  logic [OP_W-1:0]   op_q;
  logic [SET_W-1:0]  set_q;
  logic [ADDR_W-1:0] tag_q;
  logic              byp_q;
  row_t              byp_row_q;
  row_t              rd_q;
  row_t              row_mem_q [NUM_SETS];
  row_t              wr_row;

  assign wr_en = s1_adv && (op_q != OP_IFETCH);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= req_i.operation;
      set_q     <= in_set;
      tag_q     <= in_tag;
      byp_q     <= wr_en && (set_q == in_set);
      byp_row_q <= wr_row;
      rd_q      <= row_mem_q[in_set];
    end
    if (wr_en) begin
      row_mem_q[set_q] <= wr_row;
    end
  end

  // valid bits
  logic [NUM_SETS-1:0][MAX_WAYS-1:0] vld_q;
  logic [WAY_W-1:0]                  tgt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[set_q][tgt] <= 1'b1;
    end
  end

  // lookup and LRU update
  row_t              row;
  logic [MAX_WAYS-1:0] vset;
  logic [MAX_WAYS-1:0] used;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] inv;
  logic              hit;
  logic              fill;
  logic [WAY_W-1:0]  hw;
  logic [WAY_W-1:0]  fw;
  logic [WAY_W-1:0]  vw;
  logic [AGE_W-1:0]  best;
  logic [AGE_W-1:0]  lim;
  logic              nolim;
  logic [OUTC_W-1:0] outc;

  always_comb begin
    row  = byp_q ? byp_row_q : rd_q;
    vset = vld_q[set_q];
    hw   = '0;
    fw   = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      used[w]  = (w == 0) || (w < int'(ways_q));
      match[w] = used[w] && vset[w] && (row.tag[w] == tag_q);
      inv[w]   = used[w] && !vset[w];
      if (match[w]) begin
        hw = WAY_W'(w);
      end
      if (inv[w]) begin
        fw = WAY_W'(w);
      end
    end
    hit  = |match;
    fill = |inv;
    vw   = '0;
    best = row.age[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (used[w] && (row.age[w] > best)) begin
        best = row.age[w];
        vw   = WAY_W'(w);
      end
    end
    if (hit) begin
      tgt   = hw;
      lim   = row.age[hw];
      nolim = 1'b0;
      outc  = OUTC_HIT;
    end else if (fill) begin
      tgt   = fw;
      lim   = best;
      nolim = 1'b1;
      outc  = OUTC_MISS;
    end else begin
      tgt   = vw;
      lim   = best;
      nolim = 1'b0;
      outc  = OUTC_EVICT;
    end
    wr_row = row;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_W'(w) == tgt) begin
        wr_row.age[w] = '0;
        wr_row.tag[w] = tag_q;
      end else if (used[w] && vset[w] && (row.age[w] < AGE_MAX) &&
                   (nolim || (row.age[w] < lim))) begin
        wr_row.age[w] = row.age[w] + AGE_W'(1);
      end
    end
  end

  // saturating totals
  logic [CNT_W-1:0] hit_cnt_q;
  logic [CNT_W-1:0] miss_cnt_q;
  logic [CNT_W-1:0] evict_cnt_q;
  logic [CNT_W:0]   hit_sum;
  logic [CNT_W:0]   miss_sum;
  logic [CNT_W:0]   evict_sum;
  logic [CNT_W-1:0] hit_cnt_d;
  logic [CNT_W-1:0] miss_cnt_d;
  logic [CNT_W-1:0] evict_cnt_d;
  logic             is_mod;

  always_comb begin
    is_mod      = (op_q == OP_MODIFY);
    hit_sum     = {1'b0, hit_cnt_q} + (CNT_W + 1)'(hit) + (CNT_W + 1)'(is_mod);
    miss_sum    = {1'b0, miss_cnt_q} + (CNT_W + 1)'(!hit);
    evict_sum   = {1'b0, evict_cnt_q} + (CNT_W + 1)'(!hit && !fill);
    hit_cnt_d   = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
    miss_cnt_d  = miss_sum[CNT_W] ? '1 : miss_sum[CNT_W-1:0];
    evict_cnt_d = evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
    end else if (wr_en) begin
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      evict_cnt_q <= evict_cnt_d;
    end
  end

  // result register
  logic [OUTC_W-1:0] out_outc_q;
  logic              out_second_q;
  logic [CNT_W-1:0]  out_hit_q;
  logic [CNT_W-1:0]  out_miss_q;
  logic [CNT_W-1:0]  out_evict_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      if (op_q == OP_IFETCH) begin
        out_outc_q   <= OUTC_IGNORED;
        out_second_q <= 1'b0;
        out_hit_q    <= hit_cnt_q;
        out_miss_q   <= miss_cnt_q;
        out_evict_q  <= evict_cnt_q;
      end else begin
        out_outc_q   <= outc;
        out_second_q <= is_mod;
        out_hit_q    <= hit_cnt_d;
        out_miss_q   <= miss_cnt_d;
        out_evict_q  <= evict_cnt_d;
      end
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.first_outcome = out_outc_q;
  assign rsp_o.second_hit    = out_second_q;
  assign rsp_o.hit_total     = out_hit_q;
  assign rsp_o.miss_total    = out_miss_q;
  assign rsp_o.evict_total   = out_evict_q;

  // assertions
  a_hit_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> hit_cnt_q >= $past(hit_cnt_q))
    else $error("hit total decreased");

  a_miss_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> miss_cnt_q >= $past(miss_cnt_q))
    else $error("miss total decreased");

  a_evict_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> evict_cnt_q >= $past(evict_cnt_q))
    else $error("eviction total decreased");

  a_evict_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && outc == OUTC_EVICT) |=> (miss_cnt_q != $past(miss_cnt_q)) || (&miss_cnt_q))
    else $error("eviction without a counted miss");

  a_fill_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> vld_q[$past(set_q)][$past(tgt)])
    else $error("written line not marked valid");

endmodule
